FILE: rtl/rmsac_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_pkg
// Widths, codes and controller types for the relative move generator with
// step-asymmetry correction.
// ---------------------------------------------------------------------------
package rmsac_pkg;

  localparam int NUM_MOTORS_DEF = 2;

  localparam int TGT_W      = 31;
  localparam int POS_W      = 32;
  localparam int CNT_W      = 40;
  localparam int SUM_W      = 40;
  localparam int RES_W      = 18;
  localparam int STEP_W     = 33;
  localparam int CORR_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = 31;
  localparam int DIV_PRE    = QUO_W - FRAC_W;
  localparam int PROD_W     = 64;
  localparam int DIV_CNT_W  = $clog2(QUO_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CNT_W-1:0]         MIN_STEP_RST = 40'd1000;
  localparam logic [QUO_W-1:0]         F_CLAMP_LIM  = 31'h4001_0000;
  localparam logic signed [POS_W-1:0]  F_MAX        = 32'sh4000_0000;
  localparam logic signed [POS_W-1:0]  Q_ONE        = 32'sh0001_0000;
  localparam logic signed [PROD_W-1:0] Q_HALF       = 64'sd32768;
  localparam logic [DIV_CNT_W-1:0]     DIV_LAST     = DIV_CNT_W'(QUO_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AUTO_CORRECT = 2'd0,
    REG_SINGLE_STEP  = 2'd1,
    REG_MIN_STEP     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_MOVE  = 1'b0,
    MODE_CLEAR = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FSEL,
    ST_MUL,
    ST_RND,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic fsel;
    logic mul;
    logic rnd;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic drop;
    logic do_corr;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/rmsac_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_in_if
// Command request channel: move or clear, motor index, absolute target.
// ---------------------------------------------------------------------------
interface rmsac_in_if #(
  parameter int IDX_W = 1
);
  import rmsac_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [IDX_W-1:0]        motor_index;
  logic signed [TGT_W-1:0] target_position;

  modport source (output valid, mode, motor_index, target_position, input ready);
  modport sink   (input valid, mode, motor_index, target_position, output ready);
endinterface

FILE: rtl/rmsac_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_out_if
// Relative move request channel with counter and correction report.
// ---------------------------------------------------------------------------
interface rmsac_out_if #(
  parameter int IDX_W = 1
);
  import rmsac_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         motor_index_out;
  logic signed [STEP_W-1:0] move_steps;
  logic                     single_step_out;
  logic signed [CORR_W-1:0] correction_applied;
  logic [CNT_W-1:0]         increment_total;
  logic [CNT_W-1:0]         decrement_total;
  logic signed [SUM_W-1:0]  correction_total;

  modport source (output valid, motor_index_out, move_steps, single_step_out,
                  correction_applied, increment_total, decrement_total,
                  correction_total, input ready);
  modport sink   (input valid, motor_index_out, move_steps, single_step_out,
                  correction_applied, increment_total, decrement_total,
                  correction_total, output ready);
endinterface

FILE: rtl/rmsac_cfg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface rmsac_cfg_if;
  import rmsac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/relative_move_step_asymmetry_correction.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// relative_move_step_asymmetry_correction
// Turns absolute motor targets into relative move requests, stretching
// downward moves by the observed down/up step ratio.
// ---------------------------------------------------------------------------
// Channels: in_ch takes move or clear requests, out_ch delivers one move
// request per nonzero move, cfg_ch writes auto_correct_enable (0),
// single_step_mode (1) and min_step_count (2); cfg_ch is always ready.
// From accept, an uncorrected move passes ST_EVAL and ST_UPD, a corrected
// move ST_EVAL, ST_DIV, ST_FSEL, ST_MUL, ST_RND and ST_UPD, before the
// commit sets out_ch.valid. A clear, a zero move or an unknown motor emits
// nothing and frees the input after ST_EVAL. A new request is taken only
// in ST_IDLE, once the last one has been committed or dropped; the
// corrected path runs the 31-step restoring divider for the Q15.16 ratio,
// followed by factor select, one 32x32 multiply and one rounding step.
// The result waits in an output register; the next request is accepted and
// processed meanwhile, and the block holds at its commit step while out_ch
// is stalled with a result still pending.
// Reset: positions, counters, sums and residuals go to zero, min_step_count
// to 1000, the other settings to 0, out_ch.valid drops.
// ---------------------------------------------------------------------------
module relative_move_step_asymmetry_correction #(
  parameter int NUM_MOTORS = rmsac_pkg::NUM_MOTORS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rmsac_in_if.sink     in_ch,
  rmsac_out_if.source  out_ch,
  rmsac_cfg_if.sink    cfg_ch
);
  import rmsac_pkg::*;

  localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_acc;

  assign in_ch.ready  = in_ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;

  rmsac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rmsac_datapath #(
    .NUM_MOTORS (NUM_MOTORS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_mode                (in_ch.mode),
    .in_motor_index         (in_ch.motor_index),
    .in_target_position     (in_ch.target_position),
    .cfg_we                 (cfg_ch.valid),
    .cfg_index              (cfg_ch.index),
    .cfg_data               (cfg_ch.data),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_motor_index        (out_ch.motor_index_out),
    .out_move_steps         (out_ch.move_steps),
    .out_single_step        (out_ch.single_step_out),
    .out_correction_applied (out_ch.correction_applied),
    .out_increment_total    (out_ch.increment_total),
    .out_decrement_total    (out_ch.decrement_total),
    .out_correction_total   (out_ch.correction_total)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("input ready right after an accepted request");

  a_no_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_ch.valid))
    else $error("result appeared one cycle after accept");

  a_corr_downward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.correction_applied != '0)) |->
      (out_ch.move_steps[STEP_W-1] || (out_ch.move_steps == '0)))
    else $error("correction on a move that is not downward");

endmodule

FILE: rtl/rmsac_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_ctrl
// Sequencer: accept, evaluate, iterate the ratio divider, select factor,
// multiply, round, commit.
// ---------------------------------------------------------------------------
module rmsac_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rmsac_pkg::dp_status_t status,
  output rmsac_pkg::dp_cmd_t    cmd
);
  import rmsac_pkg::*;

  state_t                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (status.drop) begin
          state_nxt = ST_IDLE;
        end else if (status.do_corr) begin
          div_cnt_nxt = DIV_LAST;
          state_nxt   = ST_DIV;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = ST_FSEL;
        end else begin
          div_cnt_nxt = div_cnt_r - 1'b1;
        end
      end
      ST_FSEL: begin
        cmd.fsel  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/rmsac_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmsac_datapath
// Per-motor state, configuration registers, restoring ratio divider,
// correction multiply and rounding, saturating updates, output register.
// ---------------------------------------------------------------------------
module rmsac_datapath #(
  parameter int NUM_MOTORS = rmsac_pkg::NUM_MOTORS_DEF,
  parameter int IDX_W      = 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rmsac_pkg::dp_cmd_t                  cmd,
  output rmsac_pkg::dp_status_t               status,
  input  logic                                in_mode,
  input  logic [IDX_W-1:0]                    in_motor_index,
  input  logic signed [rmsac_pkg::TGT_W-1:0]  in_target_position,
  input  logic                                cfg_we,
  input  logic [rmsac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmsac_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [IDX_W-1:0]                    out_motor_index,
  output logic signed [rmsac_pkg::STEP_W-1:0] out_move_steps,
  output logic                                out_single_step,
  output logic signed [rmsac_pkg::CORR_W-1:0] out_correction_applied,
  output logic [rmsac_pkg::CNT_W-1:0]         out_increment_total,
  output logic [rmsac_pkg::CNT_W-1:0]         out_decrement_total,
  output logic signed [rmsac_pkg::SUM_W-1:0]  out_correction_total
);
  import rmsac_pkg::*;

  localparam int CNT_EXT_W = CNT_W + 2;
  localparam int CMP_W     = CNT_W + DIV_PRE;
  localparam int C_W       = PROD_W - FRAC_W;

  logic                    auto_r;
  logic                    single_r;
  logic [CNT_W-1:0]        min_r;

  logic                    mode_r;
  logic [IDX_W-1:0]        mot_r;
  logic signed [TGT_W-1:0] tgt_r;

  logic signed [POS_W-1:0] pos_r [NUM_MOTORS];
  logic [CNT_W-1:0]        inc_r [NUM_MOTORS];
  logic [CNT_W-1:0]        dec_r [NUM_MOTORS];
  logic signed [SUM_W-1:0] sum_r [NUM_MOTORS];
  logic signed [RES_W-1:0] res_r [NUM_MOTORS];

  logic signed [POS_W-1:0]  delta_r;
  logic                     ovf_r;
  logic [CNT_W-1:0]         rem_r;
  logic [QUO_W-1:0]         dvd_r;
  logic signed [POS_W-1:0]  f_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CORR_W-1:0] corr_r;
  logic signed [RES_W-1:0]  res_upd_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_mot_r;
  logic signed [STEP_W-1:0] out_steps_r;
  logic                     out_single_r;
  logic signed [CORR_W-1:0] out_corr_r;
  logic [CNT_W-1:0]         out_inc_r;
  logic [CNT_W-1:0]         out_dec_r;
  logic signed [SUM_W-1:0]  out_sum_r;

  logic                     mot_ok;
  logic [IDX_W-1:0]         mot_sel;
  logic signed [POS_W-1:0]  tgt_ext;
  logic signed [POS_W-1:0]  pos_cur;
  logic [CNT_W-1:0]         inc_cur;
  logic [CNT_W-1:0]         dec_cur;
  logic signed [SUM_W-1:0]  sum_cur;
  logic signed [RES_W-1:0]  res_cur;
  logic signed [POS_W-1:0]  delta_c;
  logic                     ovf_c;

  logic [CNT_W:0]           div_t;
  logic                     div_ge;
  logic                     f_clamp;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] rnd_s;
  logic signed [PROD_W-1:0] rnd_t;
  logic signed [C_W-1:0]    rnd_c;
  logic                     c_fits;
  logic signed [CORR_W-1:0] corr_c;
  logic signed [RES_W-1:0]  res_c;

  logic signed [STEP_W:0]     steps_full;
  logic signed [STEP_W-1:0]   steps_c;
  logic signed [SUM_W:0]      sum_full;
  logic signed [SUM_W-1:0]    sum_new;
  logic [CNT_W:0]             inc_full;
  logic [CNT_W-1:0]           inc_new;
  logic signed [CNT_EXT_W-1:0] dec_full;
  logic [CNT_W-1:0]           dec_new;
  logic                       delta_up;
  logic [CNT_W-1:0]           inc_wr;
  logic [CNT_W-1:0]           dec_wr;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r   <= 1'b0;
      single_r <= 1'b0;
      min_r    <= MIN_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_AUTO_CORRECT: auto_r   <= cfg_data[0];
        REG_SINGLE_STEP:  single_r <= cfg_data[0];
        REG_MIN_STEP:     min_r    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // evaluate
  assign mot_ok  = ({{(32-IDX_W){1'b0}}, mot_r} < 32'(NUM_MOTORS));
  assign mot_sel = mot_ok ? mot_r : '0;
  assign tgt_ext = POS_W'(tgt_r);
  assign pos_cur = pos_r[mot_sel];
  assign inc_cur = inc_r[mot_sel];
  assign dec_cur = dec_r[mot_sel];
  assign sum_cur = sum_r[mot_sel];
  assign res_cur = res_r[mot_sel];
  assign delta_c = tgt_ext - pos_cur;
  assign ovf_c   = ({{DIV_PRE{1'b0}}, dec_cur} >= CMP_W'({inc_cur, {DIV_PRE{1'b0}}}));

  assign status.drop     = (mode_r == MODE_CLEAR) || !mot_ok || (delta_c == '0);
  assign status.do_corr  = auto_r && delta_c[POS_W-1] && (dec_cur > min_r) &&
                           (inc_cur > min_r);
  assign status.out_free = !out_valid_r || out_ready;

  // divider step
  assign div_t  = {rem_r, dvd_r[QUO_W-1]};
  assign div_ge = (div_t >= {1'b0, inc_cur});

  // factor, product, rounding
  assign f_clamp = ovf_r || (dvd_r > F_CLAMP_LIM);
  assign prod_c  = delta_r * f_r;
  assign rnd_s   = prod_r + PROD_W'(res_upd_r);
  assign rnd_t   = rnd_s + Q_HALF;
  assign rnd_c   = rnd_t[PROD_W-1:FRAC_W];
  assign c_fits  = (rnd_c[C_W-1:CORR_W-1] == '0) || (rnd_c[C_W-1:CORR_W-1] == '1);
  assign corr_c  = c_fits ? rnd_c[CORR_W-1:0] :
                   (rnd_c[C_W-1] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}});
  assign res_c   = RES_W'($signed({~rnd_t[FRAC_W-1], rnd_t[FRAC_W-2:0]}));

  // saturating updates
  assign steps_full = (STEP_W+1)'(delta_r) + (STEP_W+1)'(corr_r);
  assign steps_c    = (steps_full[STEP_W] == steps_full[STEP_W-1]) ? steps_full[STEP_W-1:0] :
                      (steps_full[STEP_W] ? {1'b1, {(STEP_W-1){1'b0}}} :
                                            {1'b0, {(STEP_W-1){1'b1}}});
  assign sum_full   = (SUM_W+1)'(sum_cur) + (SUM_W+1)'(corr_r);
  assign sum_new    = (sum_full[SUM_W] == sum_full[SUM_W-1]) ? sum_full[SUM_W-1:0] :
                      (sum_full[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} :
                                         {1'b0, {(SUM_W-1){1'b1}}});
  assign inc_full   = {1'b0, inc_cur} + (CNT_W+1)'(delta_r);
  assign inc_new    = inc_full[CNT_W] ? '1 : inc_full[CNT_W-1:0];
  assign dec_full   = $signed({2'b00, dec_cur}) - CNT_EXT_W'(steps_full);
  assign dec_new    = dec_full[CNT_EXT_W-1] ? '0 :
                      (dec_full[CNT_W] ? '1 : dec_full[CNT_W-1:0]);
  assign delta_up   = !delta_r[POS_W-1];
  assign inc_wr     = delta_up ? inc_new : inc_cur;
  assign dec_wr     = delta_up ? dec_cur : dec_new;

  // request and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      mot_r  <= in_motor_index;
      tgt_r  <= in_target_position;
    end
    if (cmd.eval) begin
      delta_r   <= delta_c;
      corr_r    <= '0;
      res_upd_r <= res_cur;
      ovf_r     <= ovf_c;
      rem_r     <= CNT_W'(dec_cur[CNT_W-1:DIV_PRE]);
      dvd_r     <= {dec_cur[DIV_PRE-1:0], {FRAC_W{1'b0}}};
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? CNT_W'(div_t - {1'b0, inc_cur}) : div_t[CNT_W-1:0];
      dvd_r <= {dvd_r[QUO_W-2:0], div_ge};
    end
    if (cmd.fsel) begin
      f_r <= f_clamp ? F_MAX : ($signed({1'b0, dvd_r}) - Q_ONE);
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.rnd) begin
      corr_r    <= corr_c;
      res_upd_r <= res_c;
    end
  end

  // per-motor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        pos_r[i] <= '0;
        inc_r[i] <= '0;
        dec_r[i] <= '0;
        sum_r[i] <= '0;
        res_r[i] <= '0;
      end
    end else if (cmd.eval && (mode_r == MODE_CLEAR)) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        inc_r[i] <= '0;
        dec_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      pos_r[mot_sel] <= tgt_ext;
      inc_r[mot_sel] <= inc_wr;
      dec_r[mot_sel] <= dec_wr;
      sum_r[mot_sel] <= sum_new;
      res_r[mot_sel] <= res_upd_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_mot_r    <= mot_sel;
      out_steps_r  <= steps_c;
      out_single_r <= single_r;
      out_corr_r   <= corr_r;
      out_inc_r    <= inc_wr;
      out_dec_r    <= dec_wr;
      out_sum_r    <= sum_new;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_motor_index        = out_mot_r;
  assign out_move_steps         = out_steps_r;
  assign out_single_step        = out_single_r;
  assign out_correction_applied = out_corr_r;
  assign out_increment_total    = out_inc_r;
  assign out_decrement_total    = out_dec_r;
  assign out_correction_total   = out_sum_r;

endmodule
